### src/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a synchronous active-low reset as the disable term.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, built on the clocked form above.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

### src/gcpv_pkg.sv
// Package for the GPU command packet validator: codes, state and result types
// and the payload-count lookup. Depends on nothing.
package gcpv_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_REGS    = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_ABORT   = 3'd4;

    // Word roles
    localparam logic [2:0] ROLE_T0_HEADER = 3'd0;
    localparam logic [2:0] ROLE_T0_DATA   = 3'd1;
    localparam logic [2:0] ROLE_FILLER    = 3'd2;
    localparam logic [2:0] ROLE_T3_HEADER = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD   = 3'd4;
    localparam logic [2:0] ROLE_SKIPPED   = 3'd5;
    localparam logic [2:0] ROLE_IGNORED   = 3'd6;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED = 3'd1;
    localparam logic [2:0] ERR_RANGE     = 3'd2;
    localparam logic [2:0] ERR_TYPE      = 3'd3;
    localparam logic [2:0] ERR_COUNT     = 3'd4;
    localparam logic [2:0] ERR_OPCODE    = 3'd5;
    localparam logic [2:0] ERR_SHADER    = 3'd6;
    localparam logic [2:0] ERR_ABORTED   = 3'd7;

    // Packet header types
    localparam logic [1:0] PKT_TYPE0 = 2'd0;
    localparam logic [1:0] PKT_TYPE1 = 2'd1;
    localparam logic [1:0] PKT_TYPE2 = 2'd2;
    localparam logic [1:0] PKT_TYPE3 = 2'd3;

    // Type-3 opcodes
    localparam logic [6:0] OP_21           = 7'h21;
    localparam logic [6:0] OP_SHADER_LOAD  = 7'h2B;
    localparam logic [6:0] OP_36           = 7'h36;
    localparam logic [6:0] OP_3B           = 7'h3B;
    localparam logic [6:0] OP_3C           = 7'h3C;
    localparam logic [6:0] OP_45           = 7'h45;
    localparam logic [6:0] OP_46           = 7'h46;
    localparam logic [6:0] OP_48           = 7'h48;
    localparam logic [6:0] OP_BIN_MASK     = 7'h50;
    localparam logic [6:0] OP_BIN_SELECT   = 7'h51;
    localparam logic [6:0] OP_54           = 7'h54;
    localparam logic [6:0] OP_58           = 7'h58;
    localparam logic [6:0] OP_BIN_MASK_LO  = 7'h60;
    localparam logic [6:0] OP_BIN_MASK_HI  = 7'h61;
    localparam logic [6:0] OP_BIN_SEL_LO   = 7'h62;
    localparam logic [6:0] OP_BIN_SEL_HI   = 7'h63;
    localparam logic [6:0] OP_64           = 7'h64;

    localparam logic [15:0] REGISTER_COUNT_RESET = 16'd24576;

    // Parser state carried from word to word
    typedef struct packed {
        logic [2:0]  phase;
        logic [13:0] words_remaining;
        logic [13:0] payload_index;
        logic [6:0]  current_opcode;
        logic [15:0] register_cursor;
        logic        single_register;
        logic [14:0] packet_length;
        logic [63:0] mask_bits;
        logic [63:0] select_bits;
        logic [63:0] saved_mask_bits;
        logic [63:0] saved_select_bits;
    } t_state;

    // One result word
    typedef struct packed {
        logic [2:0]  word_role;
        logic [6:0]  opcode;
        logic [13:0] payload_position;
        logic [15:0] target_register;
        logic        packet_done;
        logic [2:0]  error_code;
        logic        batch_done;
    } t_result;

    // Expected payload size of a type-3 opcode
    typedef struct packed {
        logic       known;
        logic       shader;
        logic [4:0] count;
    } t_count_info;

    function automatic t_count_info required_count(input logic [6:0] op);
        t_count_info info;
        info = '{known: 1'b1, shader: 1'b0, count: 5'd0};
        case (op) inside
            OP_21, OP_58:                 info.count = 5'd3;
            OP_3C:                        info.count = 5'd5;
            OP_45:                        info.count = 5'd6;
            OP_36, OP_3B, OP_46, OP_54,
            OP_BIN_MASK_LO, OP_BIN_MASK_HI,
            OP_BIN_SEL_LO, OP_BIN_SEL_HI: info.count = 5'd1;
            OP_48:                        info.count = 5'd18;
            OP_BIN_MASK, OP_BIN_SELECT:   info.count = 5'd2;
            OP_64:                        info.count = 5'd4;
            OP_SHADER_LOAD:               info.shader = 1'b1;
            default:                      info.known = 1'b0;
        endcase
        return info;
    endfunction

endpackage

### src/gcpv_step.sv
// Per-word parse step: from the current parser state and one command word,
// forms the result word and the next state. Depends on gcpv_pkg.
module gcpv_step (
    input  gcpv_pkg::t_state  i_state,
    input  logic [31:0]       i_word,
    input  logic [15:0]       i_words_after,
    input  logic              i_overlong,
    input  logic [15:0]       i_register_count,
    output gcpv_pkg::t_state  o_state,
    output gcpv_pkg::t_result o_result
);
    import gcpv_pkg::*;

    logic [1:0]  hdr_type;
    logic [14:0] hdr_count;
    logic [14:0] hdr_base;
    logic        hdr_one;
    logic [16:0] range_end;
    logic        bins_clear;
    logic        batch_last;
    t_count_info need;
    t_state      n_state;
    t_result     res;

    // Header fields
    assign hdr_type   = i_word[31:30];
    assign hdr_count  = {1'b0, i_word[29:16]} + 15'd1;
    assign hdr_base   = i_word[14:0];
    assign hdr_one    = i_word[15];
    assign range_end  = {2'b0, hdr_base} + {2'b0, hdr_count};
    assign bins_clear = ((i_state.select_bits & i_state.mask_bits) == 64'd0);
    assign batch_last = (i_words_after == 16'd0);
    assign need       = required_count(i_word[14:8]);

    // Decode the word against the parser phase, then close the batch if it ends here
    always_comb begin
        n_state = i_state;
        res     = '0;
        res.word_role  = ROLE_IGNORED;
        res.error_code = ERR_NONE;
        res.batch_done = batch_last;

        if (i_state.phase == PH_ABORT) begin
            res.error_code = ERR_ABORTED;
        end else if (i_overlong) begin
            res.error_code = ERR_TRUNCATED;
        end else if (i_state.phase == PH_IDLE) begin
            if (hdr_type == PKT_TYPE2) begin
                res.word_role   = ROLE_FILLER;
                res.packet_done = 1'b1;
            end else begin
                if (hdr_type == PKT_TYPE0) begin
                    res.word_role = ROLE_T0_HEADER;
                end else if (hdr_type == PKT_TYPE3) begin
                    res.word_role = ROLE_T3_HEADER;
                    res.opcode    = i_word[14:8];
                end
                if ({1'b0, hdr_count} > i_words_after) begin
                    res.error_code = ERR_TRUNCATED;
                end else if (hdr_type == PKT_TYPE0) begin
                    if (!hdr_one && (range_end > {1'b0, i_register_count})) begin
                        res.error_code = ERR_RANGE;
                    end else begin
                        n_state.phase           = PH_REGS;
                        n_state.register_cursor = {1'b0, hdr_base};
                        n_state.single_register = hdr_one;
                    end
                end else if (hdr_type == PKT_TYPE1) begin
                    res.error_code = ERR_TYPE;
                end else if (i_word[0] && bins_clear) begin
                    n_state.phase = PH_SKIP;
                end else if (!need.known) begin
                    res.error_code = ERR_OPCODE;
                end else if (need.shader && (hdr_count < 15'd2)) begin
                    res.error_code = ERR_SHADER;
                end else if (!need.shader && (hdr_count != {10'd0, need.count})) begin
                    res.error_code = ERR_COUNT;
                end else begin
                    n_state.phase = PH_PAYLOAD;
                end
                n_state.current_opcode  = res.opcode;
                n_state.packet_length   = hdr_count;
                n_state.words_remaining = i_word[29:16];
                n_state.payload_index   = 14'd0;
            end
        end else begin
            res.payload_position = i_state.payload_index;
            if (i_state.phase == PH_REGS) begin
                res.word_role       = ROLE_T0_DATA;
                res.target_register = i_state.register_cursor;
                if (!i_state.single_register) begin
                    n_state.register_cursor = i_state.register_cursor + 16'd1;
                end
            end else begin
                res.opcode    = i_state.current_opcode;
                res.word_role = (i_state.phase == PH_SKIP) ? ROLE_SKIPPED : ROLE_PAYLOAD;
            end

            if (i_words_after < {2'b0, i_state.words_remaining}) begin
                res.error_code = ERR_TRUNCATED;
            end else if (i_state.phase == PH_PAYLOAD) begin
                if (i_state.current_opcode == OP_SHADER_LOAD) begin
                    // Shader load: mode word, then a size word that must match the length
                    if ((i_state.payload_index == 14'd0) && (i_word > 32'd1)) begin
                        res.error_code = ERR_SHADER;
                    end else if ((i_state.payload_index == 14'd1) &&
                                 ((i_word[31:16] != 16'd0) || (i_word[15:0] == 16'd0) ||
                                  ({2'b0, i_state.packet_length} !=
                                   (17'd2 + {1'b0, i_word[15:0]})))) begin
                        res.error_code = ERR_SHADER;
                    end
                end else if (i_state.payload_index == 14'd0) begin
                    // Bin mask and select updates, half a word at a time
                    case (i_state.current_opcode)
                        OP_BIN_MASK_LO: n_state.mask_bits[31:0]    = i_word;
                        OP_BIN_MASK_HI: n_state.mask_bits[63:32]   = i_word;
                        OP_BIN_SEL_LO:  n_state.select_bits[31:0]  = i_word;
                        OP_BIN_SEL_HI:  n_state.select_bits[63:32] = i_word;
                        OP_BIN_MASK:    n_state.mask_bits[63:32]   = i_word;
                        OP_BIN_SELECT:  n_state.select_bits[63:32] = i_word;
                        default:        n_state.mask_bits          = i_state.mask_bits;
                    endcase
                end else if (i_state.payload_index == 14'd1) begin
                    case (i_state.current_opcode)
                        OP_BIN_MASK:    n_state.mask_bits[31:0]   = i_word;
                        OP_BIN_SELECT:  n_state.select_bits[31:0] = i_word;
                        default:        n_state.mask_bits         = i_state.mask_bits;
                    endcase
                end
            end

            if (res.error_code == ERR_NONE) begin
                if (i_state.words_remaining == 14'd0) begin
                    res.packet_done = 1'b1;
                    n_state.phase   = PH_IDLE;
                end else begin
                    n_state.words_remaining = i_state.words_remaining - 14'd1;
                    n_state.payload_index   = i_state.payload_index + 14'd1;
                end
            end
        end

        // Any error aborts the rest of the batch
        if (res.error_code != ERR_NONE) begin
            n_state.phase   = PH_ABORT;
            res.packet_done = 1'b0;
        end

        // Batch end: commit or roll back the bin registers and return to idle
        if (batch_last) begin
            if (n_state.phase == PH_ABORT) begin
                n_state.mask_bits   = i_state.saved_mask_bits;
                n_state.select_bits = i_state.saved_select_bits;
            end else begin
                n_state.saved_mask_bits   = n_state.mask_bits;
                n_state.saved_select_bits = n_state.select_bits;
            end
            n_state.phase           = PH_IDLE;
            n_state.words_remaining = 14'd0;
            n_state.payload_index   = 14'd0;
        end
    end

    assign o_state  = n_state;
    assign o_result = res;

endmodule

### src/gpu_command_packet_validator.sv
// Top level of the GPU command packet validator: input register, parse step
// and result register. Depends on gcpv_pkg and gcpv_step.
//
// The validator takes one command word per clock cycle while the output is
// not stalled and returns exactly one result word per command word, in order.
// A word is first captured in an input register; the parse step then works
// out the result and the next parser state combinationally and both are
// registered together, so the parser state loop closes through a single
// register and sets that rate. A stalled result holds in the output register
// while one further word waits in the input register. The user must write the
// register count over its own port only while no batch is in flight; the block
// itself does not enforce this. That port is always ready.
module gpu_command_packet_validator #(
    parameter int unsigned BATCH_WORDS_MAX = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command words in
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_word,
    input  logic [15:0] i_words_after,
    // Result words out
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_word_role,
    output logic [6:0]  o_opcode,
    output logic [13:0] o_payload_position,
    output logic [15:0] o_target_register,
    output logic        o_packet_done,
    output logic [2:0]  o_error_code,
    output logic        o_batch_done,
    // Register count write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_register_count
);
    import gcpv_pkg::*;

    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic [15:0] r_in_after;
    logic        r_out_valid;
    t_result     r_out;
    t_state      r_state;
    logic [15:0] r_register_count;

    logic        advance;
    logic        overlong;
    t_state      n_state;
    t_result     n_result;

    // Handshakes
    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign overlong    = (32'(r_in_after) >= 32'(BATCH_WORDS_MAX));

    gcpv_step u_step (
        .i_state          (r_state),
        .i_word           (r_in_word),
        .i_words_after    (r_in_after),
        .i_overlong       (overlong),
        .i_register_count (r_register_count),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    // Control state, parser state and configuration; an all-zero state is idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_state          <= '0;
            r_register_count <= REGISTER_COUNT_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_register_count <= i_register_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_word  <= i_word;
            r_in_after <= i_words_after;
        end
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_word_role        = r_out.word_role;
    assign o_opcode           = r_out.opcode;
    assign o_payload_position = r_out.payload_position;
    assign o_target_register  = r_out.target_register;
    assign o_packet_done      = r_out.packet_done;
    assign o_error_code       = r_out.error_code;
    assign o_batch_done       = r_out.batch_done;

endmodule

### src/gcpv_checker.sv
// Port-level checker for the GPU command packet validator, bound to the top level.
// Depends on gcpv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gcpv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_word_role,
    input logic [6:0]  o_opcode,
    input logic [13:0] o_payload_position,
    input logic [15:0] o_target_register,
    input logic        o_packet_done,
    input logic [2:0]  o_error_code,
    input logic        o_batch_done
);
    import gcpv_pkg::*;

    logic        r_err_open;
    logic [45:0] out_word;
    logic        stall;
    logic        err_word;
    logic        abort_word;
    logic        pos_word;
    logic        body_word;

    // The whole result side, valid included, as one vector
    assign out_word = {o_valid, o_word_role, o_opcode, o_payload_position,
                       o_target_register, o_packet_done, o_error_code, o_batch_done};

    // Conditions watched by the assertions
    assign stall      = o_valid && !i_ready;
    assign err_word   = o_valid && (o_error_code != ERR_NONE);
    assign abort_word = o_valid && (o_error_code == ERR_ABORTED);
    assign pos_word   = o_valid && (o_payload_position != 14'd0);
    assign body_word  = (o_word_role == ROLE_T0_DATA) || (o_word_role == ROLE_PAYLOAD) ||
                        (o_word_role == ROLE_SKIPPED);

    // Tracks whether a delivered word of the current batch carried an error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_open <= 1'b0;
        end else if (o_valid && i_ready) begin
            if (o_batch_done) begin
                r_err_open <= 1'b0;
            end else if (o_error_code != ERR_NONE) begin
                r_err_open <= 1'b1;
            end
        end
    end

    // A stalled result word holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, stall |=> $stable(out_word), "stalled word moved")

    // An erroneous word never closes a packet
    `ASSERT_IMPLY(a_err_no_done, i_clk, i_rst_n, err_word, !o_packet_done, "done on an error word")

    // Aborted words only follow an error in the same batch
    `ASSERT_IMPLY(a_abort_after_err, i_clk, i_rst_n, abort_word, r_err_open, "abort with no error")

    // Only packet body words carry a payload position
    `ASSERT_IMPLY(a_pos_on_body, i_clk, i_rst_n, pos_word, body_word, "position on a header")

endmodule

bind gpu_command_packet_validator gcpv_checker u_checker (.*);

### bench/packet_result_checker.sv
// Result checker for the GPU command packet validator: watches the command,
// result and register count channels, predicts every result word and compares.
// Depends on gcpv_pkg for the code constants and the result type.
`timescale 1ns / 100ps

module packet_result_checker
    import gcpv_pkg::*;
#(
    parameter int unsigned BATCH_LIMIT = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [31:0] i_cmd_word,
    input  logic [15:0] i_cmd_words_after,
    // Result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_res_role,
    input  logic [6:0]  i_res_opcode,
    input  logic [13:0] i_res_position,
    input  logic [15:0] i_res_register,
    input  logic        i_res_packet_done,
    input  logic [2:0]  i_res_error,
    input  logic        i_res_batch_done,
    // Register count channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_count,
    // Status for the stimulus side
    output int          o_mismatch_count,
    output int          o_results_owed
);

    localparam int SIZE_UNKNOWN = -1;
    localparam int SIZE_SHADER  = 0;

    // Parser state as the block should hold it.
    logic [2:0]  phase;
    logic [13:0] words_left;
    logic [13:0] pay_index;
    logic [6:0]  cur_op;
    logic [15:0] reg_cursor;
    logic        single_reg;
    logic [14:0] pkt_len;
    logic [63:0] pred_mask;
    logic [63:0] pred_sel;
    logic [63:0] kept_mask;
    logic [63:0] kept_sel;
    logic [15:0] reg_count;

    t_result owed_results[$];

    // Payload size demanded by a type-3 opcode; the shader load has a size of
    // its own and anything not listed is an unknown opcode.
    function automatic int payload_size_of(input logic [6:0] op);
        case (op)
            OP_21, OP_58:                 return 3;
            OP_3C:                        return 5;
            OP_45:                        return 6;
            OP_36, OP_3B, OP_46, OP_54,
            OP_BIN_MASK_LO, OP_BIN_MASK_HI,
            OP_BIN_SEL_LO, OP_BIN_SEL_HI: return 1;
            OP_48:                        return 18;
            OP_BIN_MASK, OP_BIN_SELECT:   return 2;
            OP_64:                        return 4;
            OP_SHADER_LOAD:               return SIZE_SHADER;
            default:                      return SIZE_UNKNOWN;
        endcase
    endfunction

    // Works out the result of one command word and moves the parser on.
    task automatic parse_word(input logic [31:0] w, input logic [15:0] after,
                              output t_result r);
        logic [1:0]  hdr_type;
        logic [14:0] count;
        logic [14:0] base;
        logic [2:0]  err;
        int          need;
        r = '0;
        r.word_role = ROLE_IGNORED;
        r.batch_done = (after == 16'd0);
        err = ERR_NONE;
        if (phase == PH_ABORT) begin
            err = ERR_ABORTED;
        end else if (after >= BATCH_LIMIT) begin
            err = ERR_TRUNCATED;
        end else if (phase == PH_IDLE) begin
            // A header word: decode its type and size.
            hdr_type = w[31:30];
            if (hdr_type == PKT_TYPE2) begin
                r.word_role = ROLE_FILLER;
                r.packet_done = 1'b1;
            end else begin
                count = {1'b0, w[29:16]} + 15'd1;
                if (hdr_type == PKT_TYPE0)
                    r.word_role = ROLE_T0_HEADER;
                else if (hdr_type == PKT_TYPE3)
                    r.word_role = ROLE_T3_HEADER;
                if (hdr_type == PKT_TYPE3)
                    r.opcode = w[14:8];
                if (count > after) begin
                    err = ERR_TRUNCATED;
                end else if (hdr_type == PKT_TYPE0) begin
                    base = w[14:0];
                    if (!w[15] && int'(base) + int'(count) > int'(reg_count)) begin
                        err = ERR_RANGE;
                    end else begin
                        phase = PH_REGS;
                        reg_cursor = {1'b0, base};
                        single_reg = w[15];
                    end
                end else if (hdr_type == PKT_TYPE1) begin
                    err = ERR_TYPE;
                end else if (w[0] && (pred_sel & pred_mask) == 64'd0) begin
                    phase = PH_SKIP;
                end else begin
                    need = payload_size_of(r.opcode);
                    if (need == SIZE_UNKNOWN)
                        err = ERR_OPCODE;
                    else if (need == SIZE_SHADER && count < 15'd2)
                        err = ERR_SHADER;
                    else if (need > 0 && need != int'(count))
                        err = ERR_COUNT;
                    else
                        phase = PH_PAYLOAD;
                end
                cur_op = r.opcode;
                pkt_len = count;
                words_left = 14'(count - 15'd1);
                pay_index = 14'd0;
            end
        end else begin
            // A word inside a packet.
            r.payload_position = pay_index;
            if (phase == PH_REGS) begin
                r.word_role = ROLE_T0_DATA;
                r.target_register = reg_cursor;
                if (!single_reg)
                    reg_cursor = reg_cursor + 16'd1;
            end else begin
                r.opcode = cur_op;
                r.word_role = (phase == PH_SKIP) ? ROLE_SKIPPED : ROLE_PAYLOAD;
            end
            if (after < words_left) begin
                err = ERR_TRUNCATED;
            end else if (phase == PH_PAYLOAD) begin
                if (cur_op == OP_SHADER_LOAD) begin
                    if (pay_index == 14'd0 && w > 32'd1)
                        err = ERR_SHADER;
                    if (pay_index == 14'd1 && (w[31:16] != 16'd0 || w[15:0] == 16'd0
                            || int'(pkt_len) != 2 + int'(w[15:0])))
                        err = ERR_SHADER;
                end else if (pay_index == 14'd0) begin
                    // Bin writes land word by word as the payload arrives.
                    case (cur_op)
                        OP_BIN_MASK_LO:               pred_mask[31:0] = w;
                        OP_BIN_MASK_HI, OP_BIN_MASK:  pred_mask[63:32] = w;
                        OP_BIN_SEL_LO:                pred_sel[31:0] = w;
                        OP_BIN_SEL_HI, OP_BIN_SELECT: pred_sel[63:32] = w;
                        default: ;
                    endcase
                end else if (pay_index == 14'd1) begin
                    case (cur_op)
                        OP_BIN_MASK:   pred_mask[31:0] = w;
                        OP_BIN_SELECT: pred_sel[31:0] = w;
                        default: ;
                    endcase
                end
            end
            if (err == ERR_NONE) begin
                if (words_left == 14'd0) begin
                    r.packet_done = 1'b1;
                    phase = PH_IDLE;
                end else begin
                    words_left = words_left - 14'd1;
                    pay_index = pay_index + 14'd1;
                end
            end
        end

        if (err != ERR_NONE) begin
            phase = PH_ABORT;
            r.packet_done = 1'b0;
        end
        r.error_code = err;

        // At the batch end the bin state is either kept or rolled back.
        if (after == 16'd0) begin
            if (phase == PH_ABORT) begin
                pred_mask = kept_mask;
                pred_sel = kept_sel;
            end else begin
                kept_mask = pred_mask;
                kept_sel = pred_sel;
            end
            phase = PH_IDLE;
            words_left = 14'd0;
            pay_index = 14'd0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            phase = PH_IDLE;
            words_left = '0;
            pay_index = '0;
            cur_op = '0;
            reg_cursor = '0;
            single_reg = 1'b0;
            pkt_len = '0;
            pred_mask = '0;
            pred_sel = '0;
            kept_mask = '0;
            kept_sel = '0;
            reg_count = REGISTER_COUNT_RESET;
            owed_results.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                reg_count = i_cfg_count;

            // Each accepted command word owes exactly one result word.
            if (i_cmd_valid && i_cmd_ready) begin
                parse_word(i_cmd_word, i_cmd_words_after, want);
                owed_results.insert(owed_results.size(), want);
            end

            if (i_res_valid && i_res_ready) begin
                seen = '{word_role: i_res_role, opcode: i_res_opcode,
                         payload_position: i_res_position, target_register: i_res_register,
                         packet_done: i_res_packet_done, error_code: i_res_error,
                         batch_done: i_res_batch_done};
                if (owed_results.size() == 0) begin
                    if (o_mismatch_count < 10)
                        $display("%0t: result word with no command word outstanding:",
                                 $realtime);
                    if (o_mismatch_count < 10)
                        $display("    role=%0d err=%0d", seen.word_role, seen.error_code);
                    o_mismatch_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (seen !== want) begin
                        if (o_mismatch_count < 10) begin
                            $display("%0t: result mismatch, expected role=%0d op=%h pos=%0d",
                                     $realtime, want.word_role, want.opcode,
                                     want.payload_position);
                            $display("    reg=%0d pdone=%0b err=%0d bdone=%0b",
                                     want.target_register, want.packet_done,
                                     want.error_code, want.batch_done);
                            $display("    got role=%0d op=%h pos=%0d reg=%0d",
                                     seen.word_role, seen.opcode, seen.payload_position,
                                     seen.target_register);
                            $display("    pdone=%0b err=%0d bdone=%0b",
                                     seen.packet_done, seen.error_code, seen.batch_done);
                        end
                        o_mismatch_count++;
                    end
                end
            end
        end
        o_results_owed = owed_results.size();
    end

endmodule

### bench/tb.sv
// Top of the testbench for the GPU command packet validator: clock, reset,
// command batches, result stalls, register count writes and the verdict.
// Depends on gcpv_pkg, the validator and packet_result_checker.
`timescale 1ns / 100ps

module tb;
    import gcpv_pkg::*;

    localparam int PHASE_WORDS = 75;
    localparam int CALM_AFTER  = 400;
    localparam int CYCLE_LIMIT = 150000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_word = '0;
    logic [15:0] i_words_after = '0;
    logic        o_valid;
    logic        i_ready = 1'b1;
    logic [2:0]  o_word_role;
    logic [6:0]  o_opcode;
    logic [13:0] o_payload_position;
    logic [15:0] o_target_register;
    logic        o_packet_done;
    logic [2:0]  o_error_code;
    logic        o_batch_done;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_register_count = REGISTER_COUNT_RESET;

    int mismatches;
    int results_owed;

    // Stimulus state
    logic [31:0] batch_q[$];
    logic [15:0] reg_count_now = REGISTER_COUNT_RESET;
    int          gap_rate = 0;
    int          words_sent = 0;
    bit          calm = 1'b0;
    int          cycles = 0;
    int          stall_left = 0;
    int          stall_rate = 0;
    int          regime_left = 0;

    gpu_command_packet_validator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_word             (i_word),
        .i_words_after      (i_words_after),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_word_role        (o_word_role),
        .o_opcode           (o_opcode),
        .o_payload_position (o_payload_position),
        .o_target_register  (o_target_register),
        .o_packet_done      (o_packet_done),
        .o_error_code       (o_error_code),
        .o_batch_done       (o_batch_done),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_register_count   (i_register_count)
    );

    packet_result_checker result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (i_valid),
        .i_cmd_ready       (o_ready),
        .i_cmd_word        (i_word),
        .i_cmd_words_after (i_words_after),
        .i_res_valid       (o_valid),
        .i_res_ready       (i_ready),
        .i_res_role        (o_word_role),
        .i_res_opcode      (o_opcode),
        .i_res_position    (o_payload_position),
        .i_res_register    (o_target_register),
        .i_res_packet_done (o_packet_done),
        .i_res_error       (o_error_code),
        .i_res_batch_done  (o_batch_done),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_count       (i_register_count),
        .o_mismatch_count  (mismatches),
        .o_results_owed    (results_owed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung handshake.
    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles == CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: stall bursts at a rate that changes from stretch to stretch,
    // some stretches without any stall.
    initial begin
        forever begin
            @(posedge i_clk);
            if (regime_left == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_rate = 0;
                    1: stall_rate = 4;
                    default: stall_rate = 12;
                endcase
                regime_left = $urandom_range(20, 80);
            end
            regime_left--;
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!calm && stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
                i_ready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Adds one word to the end of the batch being built.
    function automatic void append_word(input logic [31:0] w);
        batch_q.insert(batch_q.size(), w);
    endfunction

    function automatic logic [31:0] t0_header(input logic [14:0] base, input int count,
                                              input logic one);
        return {PKT_TYPE0, 14'(count - 1), one, base};
    endfunction

    function automatic logic [31:0] t3_header(input logic [6:0] op, input int count,
                                              input logic pred);
        return {PKT_TYPE3, 14'(count - 1), 1'($urandom), op, 7'($urandom), pred};
    endfunction

    // A known opcode and the payload size it needs (zero for the shader load).
    function automatic void pick_known_op(output logic [6:0] op, output int size);
        case ($urandom_range(0, 16))
            0:  begin op = OP_21;          size = 3;  end
            1:  begin op = OP_58;          size = 3;  end
            2:  begin op = OP_3C;          size = 5;  end
            3:  begin op = OP_45;          size = 6;  end
            4:  begin op = OP_36;          size = 1;  end
            5:  begin op = OP_3B;          size = 1;  end
            6:  begin op = OP_46;          size = 1;  end
            7:  begin op = OP_54;          size = 1;  end
            8:  begin op = OP_BIN_MASK_LO; size = 1;  end
            9:  begin op = OP_BIN_MASK_HI; size = 1;  end
            10: begin op = OP_BIN_SEL_LO;  size = 1;  end
            11: begin op = OP_BIN_SEL_HI;  size = 1;  end
            12: begin op = OP_48;          size = 18; end
            13: begin op = OP_BIN_MASK;    size = 2;  end
            14: begin op = OP_BIN_SELECT;  size = 2;  end
            15: begin op = OP_64;          size = 4;  end
            default: begin op = OP_SHADER_LOAD; size = 0; end
        endcase
    endfunction

    // Offers one command word, with a random gap in front of it now and then.
    task automatic send_word(input logic [31:0] w, input logic [15:0] after);
        int gap;
        if (!calm && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word <= w;
        i_words_after <= after;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Holds the command side until every result word has come back.
    task automatic drain_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (results_owed == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register_count(input logic [15:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_register_count <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        reg_count_now = value;
    endtask

    // Fills batch_q with a few packets, mostly well formed, some broken.
    task automatic build_batch;
        int          packets;
        int          count;
        int          base;
        int          lo;
        int          pick;
        logic        one;
        logic        pred;
        logic [6:0]  op;
        logic [31:0] w0;
        logic [31:0] w1;
        batch_q.delete();
        packets = $urandom_range(1, 5);
        repeat (packets) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                append_word({PKT_TYPE2, 30'($urandom)});
            end else if (pick < 35) begin
                // Register write, usually inside the register file.
                count = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                one = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 9);
                if (pick < 7 && count <= int'(reg_count_now))
                    base = $urandom_range(0, int'(reg_count_now) - count);
                else if (pick < 9)
                    base = int'(reg_count_now) - count + 1;
                else
                    base = $urandom_range(0, 32767);
                append_word(t0_header(15'(base), count, one));
                repeat (count) append_word($urandom);
            end else if (pick < 80) begin
                // Well-formed opcode packet, sometimes predicated.
                pick_known_op(op, count);
                pred = ($urandom_range(0, 3) == 0);
                if (op == OP_SHADER_LOAD) begin
                    lo = $urandom_range(1, 5);
                    append_word(t3_header(op, lo + 2, pred));
                    append_word(32'($urandom_range(0, 1)));
                    append_word(32'(lo));
                    repeat (lo) append_word($urandom);
                end else begin
                    append_word(t3_header(op, count, pred));
                    repeat (count) begin
                        case ($urandom_range(0, 7))
                            0, 1: append_word(32'h0000_0000);
                            2:    append_word(32'hFFFF_FFFF);
                            default: append_word($urandom);
                        endcase
                    end
                end
            end else begin
                case ($urandom_range(0, 4))
                    0: begin
                        // Type-one header followed by leftovers.
                        append_word({PKT_TYPE1, 30'($urandom)});
                        repeat ($urandom_range(0, 3)) append_word($urandom);
                    end
                    1: begin
                        // Opcode picked at random, mostly unknown.
                        count = $urandom_range(1, 4);
                        append_word(t3_header(7'($urandom), count, 1'b0));
                        repeat (count) append_word($urandom);
                    end
                    2: begin
                        // Known opcode with the wrong payload size.
                        pick_known_op(op, count);
                        if (op == OP_SHADER_LOAD)
                            count = 1;
                        else if (count == 1 || $urandom_range(0, 1) == 1)
                            count = count + 1;
                        else
                            count = count - 1;
                        append_word(t3_header(op, count, 1'b0));
                        repeat (count) append_word($urandom);
                    end
                    3: begin
                        // Shader load with one thing wrong in it.
                        lo = $urandom_range(1, 4);
                        w0 = 32'($urandom_range(0, 1));
                        w1 = 32'(lo);
                        count = lo + 2;
                        case ($urandom_range(0, 3))
                            0: begin
                                w0 = $urandom;
                                if (w0 < 32'd2)
                                    w0 = 32'd2;
                            end
                            1: w1 = {16'($urandom_range(1, 65535)), 16'(lo)};
                            2: w1 = 32'd0;
                            default: count = ($urandom_range(0, 1) == 1) ? lo + 3 : lo + 1;
                        endcase
                        append_word(t3_header(OP_SHADER_LOAD, count, 1'b0));
                        append_word(w0);
                        append_word(w1);
                        repeat (count - 2) append_word($urandom);
                    end
                    default: append_word($urandom);
                endcase
            end
        end
    endtask

    // Sends one batch, now and then cut short or with a bad word count.
    task automatic run_batch;
        int keep;
        int after;
        build_batch();
        if ($urandom_range(0, 9) == 0 && batch_q.size() > 1) begin
            keep = $urandom_range(1, batch_q.size() - 1);
            while (batch_q.size() > keep) void'(batch_q.pop_back());
        end
        case ($urandom_range(0, 2))
            0: gap_rate = 0;
            1: gap_rate = 3;
            default: gap_rate = 10;
        endcase
        foreach (batch_q[i]) begin
            after = batch_q.size() - 1 - i;
            if (after != 0 && $urandom_range(0, 39) == 0)
                after = $urandom_range(0, 65535);
            send_word(batch_q[i], 16'(after));
        end
    endtask

    initial begin : stimulus
        int phase_start;
        logic [15:0] phase_counts[5];
        phase_counts[0] = 16'd32768;
        phase_counts[1] = 16'd1;
        phase_counts[2] = 16'($urandom_range(1, 32768));
        phase_counts[3] = 16'd32767;
        phase_counts[4] = REGISTER_COUNT_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset register count, empty bin state.
        gap_rate = 3;
        send_word(32'h8000_0000, 16'd0);
        send_word(t0_header(15'd0, 1, 1'b0), 16'd1);
        send_word(32'hFFFF_FFFF, 16'd0);
        // Largest header, nothing after it: truncated.
        send_word(32'hFFFF_FFFF, 16'd0);
        send_word({PKT_TYPE1, 30'd0}, 16'd1);
        send_word(32'h0000_0000, 16'd0);
        // Register write past the end of the register file.
        send_word(t0_header(15'h7FFF, 1, 1'b0), 16'd1);
        send_word(32'h0000_0000, 16'd0);
        send_word(t3_header(7'h7F, 1, 1'b0), 16'd1);
        send_word(32'h0000_0000, 16'd0);
        send_word(t3_header(OP_21, 2, 1'b0), 16'd2);
        send_word(32'h0000_0001, 16'd1);
        send_word(32'h0000_0002, 16'd0);
        // Predicated packet while the bin state is empty is skipped.
        send_word(t3_header(OP_36, 1, 1'b1), 16'd1);
        send_word(32'h1234_5678, 16'd0);
        send_word(t3_header(OP_SHADER_LOAD, 3, 1'b0), 16'd3);
        send_word(32'h0000_0001, 16'd2);
        send_word(32'h0000_0001, 16'd1);
        send_word(32'h0000_DEAD, 16'd0);
        send_word(t3_header(OP_SHADER_LOAD, 1, 1'b0), 16'd1);
        send_word(32'h0000_0000, 16'd0);
        // Payload word arriving with too few words left behind it.
        send_word(t3_header(OP_BIN_MASK, 2, 1'b0), 16'd2);
        send_word(32'hFFFF_FFFF, 16'd0);
        send_word(32'h8000_0000, 16'hFFFF);
        send_word(32'h8000_0000, 16'd0);

        // Random batches over several register file sizes.
        foreach (phase_counts[p]) begin
            write_register_count(phase_counts[p]);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                if (words_sent >= CALM_AFTER)
                    calm = 1'b1;
                run_batch();
            end
        end

        drain_results();
        if (mismatches == 0 && results_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
